// File: rtl/sfp_pkg.sv
package sfp_pkg;

    localparam int FIELDS_PER_FRAME_DEF = 6;
    localparam int FRACTION_DIGITS_DEF  = 6;

    localparam int POSITION_FIELD = 5;
    localparam int SIGNAL_FIELD   = 6;

    localparam int INT_W = 32;
    localparam int POS_W = 48;
    localparam int ACC_W = 48;
    localparam int SUM_W = 52;
    localparam int POW_W = 24;
    localparam int ADD_W = 28;
    localparam int EXP_W = 3;

    localparam logic [ACC_W-1:0] INT_LIM = 48'h0000_7FFF_FFFF;
    localparam logic [ACC_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_S     = 8'h53;

    function automatic logic [POW_W-1:0] pow10(input logic [EXP_W-1:0] e);
        logic [POW_W-1:0] p;
        case (e)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/status_frame_parser.sv
// Parses a comma-separated character stream of frames "S,f1,...,fN,E" and
// emits one result per well-formed frame. Newline and NUL bytes are dropped;
// outside a frame every token is discarded until a lone "S" token. Fields
// are read like stoi (whitespace, sign, digits, trailing junk ignored);
// field five is a decimal scaled by 10^POSITION_FRACTION_DIGITS and
// truncated. A frame with a wrong field count, a field without digits or
// an out-of-range value gives no result. s_axis_tlast marks the end of a
// received chunk and also closes a pending "E" token. The block takes one
// byte per clock cycle unless the output stalls; a byte goes through the
// input register and one digit accumulate step into the output register.
// No clearing pass is needed after reset.
module status_frame_parser
    import sfp_pkg::*;
#(
    parameter int FIELDS_PER_FRAME         = FIELDS_PER_FRAME_DEF,
    parameter int POSITION_FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte
    input  logic         s_axis_tlast,   // end_of_chunk
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // first_status, second_status, third_status, detect_result,
    // position_scaled, signal_code
    output logic [207:0] m_axis_tdata
);

    localparam int TIW = $clog2(FIELDS_PER_FRAME + 2);
    localparam int FDW = (POSITION_FRACTION_DIGITS > 0) ?
                         $clog2(POSITION_FRACTION_DIGITS + 1) : 1;

    typedef enum logic [2:0] {
        PH_START, PH_SIGN, PH_INT, PH_DOT, PH_FRAC, PH_DONE, PH_FAIL
    } t_phase;

    typedef enum logic [1:0] {
        LM_EMPTY, LM_S, LM_E, LM_OTHER
    } t_letter;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic             r_in_frame,      n_in_frame;
    logic [TIW-1:0]   r_token_index,   n_token_index;
    t_phase           r_phase,         n_phase;
    t_letter          r_letter,        n_letter;
    logic [ACC_W-1:0] r_acc,           n_acc;
    logic             r_negative,      n_negative;
    logic [FDW-1:0]   r_frac_digits,   n_frac_digits;
    logic             r_frame_bad,     n_frame_bad;
    logic [INT_W-1:0] r_cap_int [5];
    logic [INT_W-1:0] n_cap_int [5];
    logic [POS_W-1:0] r_cap_pos,       n_cap_pos;

    logic             r_out_valid;
    logic [207:0]     r_out_data;

    logic             w_adv;
    logic             w_go;
    logic             w_emit;
    logic             w_is_dec;
    logic             w_digit;
    logic             w_frac_mode;
    logic             w_frac_room;
    logic [ACC_W-1:0] w_lim;
    logic [ACC_W-1:0] w_digit_acc;
    logic [SUM_W-1:0] w_base;
    logic [ADD_W-1:0] w_addend;
    logic [SUM_W-1:0] w_sum;
    logic [EXP_W-1:0] w_exp;
    logic [ACC_W-1:0] w_signed_val;
    logic             w_frame_ok;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_go          = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // digit accumulate, kept already scaled for the decimal field
    always_comb begin
        w_is_dec    = r_in_frame && (int'(r_token_index) == POSITION_FIELD);
        w_lim       = w_is_dec ? (POS_LIM + ACC_W'(r_negative))
                               : (INT_LIM + ACC_W'(r_negative));
        w_digit     = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
        w_frac_mode = (r_phase == PH_DOT) || (r_phase == PH_FRAC);
        w_frac_room = int'(r_frac_digits) < POSITION_FRACTION_DIGITS;
        if (w_frac_mode) begin
            w_exp  = EXP_W'(POSITION_FRACTION_DIGITS - 1 - int'(r_frac_digits));
            w_base = SUM_W'(r_acc);
        end else begin
            w_exp  = w_is_dec ? EXP_W'(POSITION_FRACTION_DIGITS) : EXP_W'(0);
            w_base = (SUM_W'(r_acc) << 3) + (SUM_W'(r_acc) << 1);
        end
        w_addend = ADD_W'(r_in_byte[3:0]) * ADD_W'(pow10(w_exp));
        w_sum    = w_base + SUM_W'(w_addend);
        if (r_acc > w_lim) begin
            w_digit_acc = r_acc;
        end else if (w_sum > SUM_W'(w_lim)) begin
            w_digit_acc = w_lim + ACC_W'(1);
        end else begin
            w_digit_acc = w_sum[ACC_W-1:0];
        end
        w_signed_val = r_negative ? (ACC_W'(0) - r_acc) : r_acc;
        w_frame_ok   = (int'(r_token_index) == FIELDS_PER_FRAME + 1) && !r_frame_bad;
    end

    always_comb begin
        n_in_frame    = r_in_frame;
        n_token_index = r_token_index;
        n_phase       = r_phase;
        n_letter      = r_letter;
        n_acc         = r_acc;
        n_negative    = r_negative;
        n_frac_digits = r_frac_digits;
        n_frame_bad   = r_frame_bad;
        n_cap_int     = r_cap_int;
        n_cap_pos     = r_cap_pos;
        w_emit        = 1'b0;

        if (r_in_byte != CHAR_LF && r_in_byte != CHAR_NUL) begin
            if (r_in_byte == CHAR_COMMA) begin
                if (r_letter == LM_S) begin
                    n_in_frame    = 1'b1;
                    n_token_index = TIW'(1);
                    n_frame_bad   = 1'b0;
                    for (int i = 0; i < 5; i++) begin
                        n_cap_int[i] = '0;
                    end
                    n_cap_pos = '0;
                end else if (r_in_frame) begin
                    if (r_letter == LM_E) begin
                        w_emit     = w_frame_ok;
                        n_in_frame = 1'b0;
                    end else if (int'(r_token_index) > FIELDS_PER_FRAME) begin
                        n_frame_bad = 1'b1;
                    end else begin
                        n_token_index = r_token_index + TIW'(1);
                        if (!(r_phase == PH_INT || r_phase == PH_FRAC ||
                              r_phase == PH_DONE) || r_acc > w_lim) begin
                            n_frame_bad = 1'b1;
                        end else if (int'(r_token_index) == POSITION_FIELD) begin
                            n_cap_pos = w_signed_val;
                        end else if (int'(r_token_index) < POSITION_FIELD) begin
                            for (int i = 0; i < 4; i++) begin
                                if (int'(r_token_index) == i + 1) begin
                                    n_cap_int[i] = w_signed_val[INT_W-1:0];
                                end
                            end
                        end else if (int'(r_token_index) == SIGNAL_FIELD) begin
                            n_cap_int[4] = w_signed_val[INT_W-1:0];
                        end
                    end
                end
                n_phase       = PH_START;
                n_letter      = LM_EMPTY;
                n_acc         = '0;
                n_negative    = 1'b0;
                n_frac_digits = '0;
            end else begin
                if (r_letter == LM_EMPTY) begin
                    n_letter = (r_in_byte == CHAR_S) ? LM_S :
                               (r_in_byte == CHAR_E) ? LM_E : LM_OTHER;
                end else begin
                    n_letter = LM_OTHER;
                end
                case (r_phase)
                    PH_START: begin
                        if (r_in_byte == CHAR_SPACE ||
                            (r_in_byte >= CHAR_TAB && r_in_byte <= CHAR_CR)) begin
                            n_phase = PH_START;
                        end else if (r_in_byte == CHAR_PLUS ||
                                     r_in_byte == CHAR_MINUS) begin
                            n_negative = r_in_byte == CHAR_MINUS;
                            n_phase    = PH_SIGN;
                        end else if (w_digit) begin
                            n_acc   = w_digit_acc;
                            n_phase = PH_INT;
                        end else begin
                            n_phase = (r_in_byte == CHAR_DOT && w_is_dec) ?
                                      PH_DOT : PH_FAIL;
                        end
                    end
                    PH_SIGN: begin
                        if (w_digit) begin
                            n_acc   = w_digit_acc;
                            n_phase = PH_INT;
                        end else begin
                            n_phase = (r_in_byte == CHAR_DOT && w_is_dec) ?
                                      PH_DOT : PH_FAIL;
                        end
                    end
                    PH_INT: begin
                        if (w_digit) begin
                            n_acc = w_digit_acc;
                        end else begin
                            n_phase = (r_in_byte == CHAR_DOT && w_is_dec) ?
                                      PH_FRAC : PH_DONE;
                        end
                    end
                    PH_DOT: begin
                        if (w_digit) begin
                            if (w_frac_room) begin
                                n_acc         = w_digit_acc;
                                n_frac_digits = r_frac_digits + FDW'(1);
                            end
                            n_phase = PH_FRAC;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_FRAC: begin
                        if (w_digit) begin
                            if (w_frac_room) begin
                                n_acc         = w_digit_acc;
                                n_frac_digits = r_frac_digits + FDW'(1);
                            end
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end

        // end of chunk
        if (r_in_last) begin
            if (n_in_frame) begin
                if (n_letter == LM_E) begin
                    w_emit        = w_frame_ok;
                    n_in_frame    = 1'b0;
                    n_phase       = PH_START;
                    n_letter      = LM_EMPTY;
                    n_acc         = '0;
                    n_negative    = 1'b0;
                    n_frac_digits = '0;
                end else if (n_letter == LM_S) begin
                    n_in_frame = 1'b0;
                end
            end else if (n_letter != LM_S) begin
                n_phase       = PH_START;
                n_letter      = LM_EMPTY;
                n_acc         = '0;
                n_negative    = 1'b0;
                n_frac_digits = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_in_frame    <= 1'b0;
            r_token_index <= '0;
            r_phase       <= PH_START;
            r_letter      <= LM_EMPTY;
            r_acc         <= '0;
            r_negative    <= 1'b0;
            r_frac_digits <= '0;
            r_frame_bad   <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= w_go && w_emit;
            end
            if (w_go) begin
                r_in_frame    <= n_in_frame;
                r_token_index <= n_token_index;
                r_phase       <= n_phase;
                r_letter      <= n_letter;
                r_acc         <= n_acc;
                r_negative    <= n_negative;
                r_frac_digits <= n_frac_digits;
                r_frame_bad   <= n_frame_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_go) begin
            r_cap_int <= n_cap_int;
            r_cap_pos <= n_cap_pos;
        end
        if (w_go && w_emit) begin
            r_out_data <= {r_cap_int[4], r_cap_pos, r_cap_int[3], r_cap_int[2],
                           r_cap_int[1], r_cap_int[0]};
        end
    end

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_token_index) <= FIELDS_PER_FRAME + 1)
        else $error("token index beyond frame length");

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= POS_LIM + ACC_W'(2))
        else $error("accumulator beyond saturation value");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_frac_digits) <= POSITION_FRACTION_DIGITS)
        else $error("too many fraction digits kept");

    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_emit) |=> (!r_in_frame && r_out_valid))
        else $error("result without frame close");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending byte lost while stalled");

endmodule
